[hw/rtl/assert_macros.svh]
// assertion macros shared by the frame parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside of reset
`define XCFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every edge, reset included
`define XCFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hw/rtl/xcfp_pkg.sv]
// shared types and header characters of the frame parser
package xcfp_pkg;

   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // fixed part of the checksum seed, the length byte is folded in later
   localparam logic [7:0] HDR_XOR = CHAR_U ^ CHAR_N ^ CHAR_E ^ CHAR_R ^ CHAR_COLON;

   typedef struct packed {
      logic [7:0] data_out;
      logic       body_valid;
      logic       first_body;
      logic       frame_ok;
      logic       frame_bad;
   } rsp_word_type;

endpackage

[hw/rtl/xcfp_chan_if.sv]
// valid/ready channel interfaces for received bytes and marked result words
interface xcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       body_valid;
   logic       first_body;
   logic       frame_ok;
   logic       frame_bad;

   modport source (output valid, output data_out, output body_valid, output first_body,
                   output frame_ok, output frame_bad, input ready);
   modport sink (input valid, input data_out, input body_valid, input first_body,
                 input frame_ok, input frame_bad, output ready);
endinterface

[hw/rtl/xor_checked_frame_parser_top.sv]
// Frame parser for a received byte stream: hunts for the header U N E R, length L and ':',
// then marks the L-1 body bytes (the first as the ID) and flags the last byte as a good or
// bad xor checksum. Every accepted byte yields exactly one registered result word,
// carrying the byte unchanged plus its marks. One byte is taken every cycle: the whole
// per-byte update is one state transition and one xor, and the single result register
// is refilled in the same cycle it is drained, so req_chan.ready stays high as long as
// the result register is empty or rsp_chan.ready is high.
`include "assert_macros.svh"

module xor_checked_frame_parser_top (
   input  logic       clock,
   input  logic       reset,
   xcfp_req_if.sink   req_chan,
   xcfp_rsp_if.source rsp_chan
);

   logic                   accept;
   logic                   rsp_valid_ff, rsp_valid_in;
   xcfp_pkg::rsp_word_type word;
   xcfp_pkg::rsp_word_type rsp_word_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   xcfp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .word    (word)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= word;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.data_out   = rsp_word_ff.data_out;
   assign rsp_chan.body_valid = rsp_word_ff.body_valid;
   assign rsp_chan.first_body = rsp_word_ff.first_body;
   assign rsp_chan.frame_ok   = rsp_word_ff.frame_ok;
   assign rsp_chan.frame_bad  = rsp_word_ff.frame_bad;

   `XCFP_ASSERT(a_word_out, accept |=> rsp_valid_ff && rsp_word_ff.data_out == $past(req_chan.rx_byte), "accepted word not presented")
   `XCFP_ASSERT(a_marks_excl, rsp_valid_ff |-> $countones({rsp_word_ff.body_valid, rsp_word_ff.frame_ok, rsp_word_ff.frame_bad}) <= 1, "conflicting marks on one word")
   `XCFP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff, "result register not empty after reset")

endmodule

[hw/rtl/xcfp_core.sv]
// frame hunting state machine: header match, length count and running xor
`include "assert_macros.svh"

module xcfp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output xcfp_pkg::rsp_word_type word
);

   typedef enum logic [2:0] {
      PH_WAIT_U     = 3'd0,
      PH_WAIT_N     = 3'd1,
      PH_WAIT_E     = 3'd2,
      PH_WAIT_R     = 3'd3,
      PH_LEN        = 3'd4,
      PH_COLON      = 3'd5,
      PH_BODY_FIRST = 3'd6,
      PH_BODY       = 3'd7
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] left_dec;

   // a mismatching header byte may itself open a new frame
   function automatic phase_type hunt_start(input logic [7:0] b);
      return (b == xcfp_pkg::CHAR_U) ? PH_WAIT_N : PH_WAIT_U;
   endfunction

   assign left_dec = left_ff - 8'd1;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      xor_in   = xor_ff;
      word     = '{data_out: rx_byte, body_valid: 1'b0, first_body: 1'b0,
                   frame_ok: 1'b0, frame_bad: 1'b0};
      unique case (phase_ff)
         PH_WAIT_U: phase_in = hunt_start(rx_byte);
         PH_WAIT_N: begin
            if (rx_byte == xcfp_pkg::CHAR_N) begin
               phase_in = PH_WAIT_E;
            end else if (rx_byte != xcfp_pkg::CHAR_U) begin
               phase_in = PH_WAIT_U;
            end
         end
         PH_WAIT_E: phase_in = (rx_byte == xcfp_pkg::CHAR_E) ? PH_WAIT_R : hunt_start(rx_byte);
         PH_WAIT_R: phase_in = (rx_byte == xcfp_pkg::CHAR_R) ? PH_LEN : hunt_start(rx_byte);
         PH_LEN: begin
            left_in  = rx_byte;
            phase_in = PH_COLON;
         end
         PH_COLON: begin
            if (rx_byte == xcfp_pkg::CHAR_COLON) begin
               xor_in   = xcfp_pkg::HDR_XOR ^ left_ff;
               phase_in = PH_BODY_FIRST;
            end else begin
               phase_in = hunt_start(rx_byte);
            end
         end
         PH_BODY_FIRST, PH_BODY: begin
            // a length of zero wraps to 255 body bytes
            left_in = left_dec;
            if (left_dec != 8'd0) begin
               word.body_valid = 1'b1;
               word.first_body = (phase_ff == PH_BODY_FIRST);
               xor_in          = xor_ff ^ rx_byte;
               phase_in        = PH_BODY;
            end else begin
               word.frame_ok  = (rx_byte == xor_ff);
               word.frame_bad = (rx_byte != xor_ff);
               phase_in       = PH_WAIT_U;
            end
         end
         default: phase_in = PH_WAIT_U;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_U;
         left_ff  <= 8'd0;
         xor_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         xor_ff   <= xor_in;
      end
   end

   `XCFP_ASSERT(a_len_latched, accept && phase_ff == PH_LEN |=> left_ff == $past(rx_byte), "length byte not latched")
   `XCFP_ASSERT(a_check_ends, accept && (word.frame_ok || word.frame_bad) |=> phase_ff == PH_WAIT_U, "hunt did not restart after checksum")
   `XCFP_ASSERT(a_body_phase, word.body_valid |-> (phase_ff == PH_BODY_FIRST || phase_ff == PH_BODY), "body mark outside body phase")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the xor checked frame parser: directed rows, random framed traffic, paced channels
module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 200;
   localparam int PHASE_ITEMS = 130;
   localparam int NUM_PHASES  = 4;
   localparam int DIR_ROWS    = 25;
   localparam int END_SETTLE  = 10;

   // marks in port order: body_valid, first_body, frame_ok, frame_bad
   localparam logic [3:0] MARK_NONE  = 4'b0000;
   localparam logic [3:0] MARK_FIRST = 4'b1100;
   localparam logic [3:0] MARK_BODY  = 4'b1000;
   localparam logic [3:0] MARK_BAD   = 4'b0001;

   typedef enum logic [2:0] {
      HUNT_U, HUNT_N, HUNT_E, HUNT_R, GET_LEN, GET_COLON, BODY_FIRST, BODY_REST
   } hunt_phase_type;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      logic [3:0] marks;
   } dir_row_type;

   typedef struct {
      bit                     typed;
      xcfp_pkg::rsp_word_type word;
   } typed_word_type;

   logic clock = 1'b0;
   logic reset;

   xcfp_req_if req_chan ();
   xcfp_rsp_if rsp_chan ();

   xor_checked_frame_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state as predicted
   hunt_phase_type hunt_phase = HUNT_U;
   logic [7:0]     bytes_due  = 8'd0;
   logic [7:0]     frame_xor  = 8'd0;

   typed_word_type         typed_q [$];
   xcfp_pkg::rsp_word_type expected_words [$];

   int fail_count  = 0;
   int sent_count  = 0;
   int word_count  = 0;
   int body_count  = 0;
   int ok_count    = 0;
   int bad_count   = 0;
   int cycle_count = 0;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit stall_request = 1'b0;

   dir_row_type dir_table [DIR_ROWS] = '{
      '{8'h00,                1'b1, MARK_NONE},
      '{8'hFF,                1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_U,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_U,     1'b1, MARK_NONE},  // repeated u keeps waiting for n
      '{xcfp_pkg::CHAR_N,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_E,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_R,     1'b1, MARK_NONE},
      '{8'h03,                1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_COLON, 1'b1, MARK_NONE},
      '{8'hA5,                1'b1, MARK_FIRST},
      '{8'h00,                1'b1, MARK_BODY},
      '{8'h90,                1'b0, MARK_NONE},  // good checksum
      '{xcfp_pkg::CHAR_U,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_N,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_U,     1'b1, MARK_NONE},  // wrong where e is due, taken as a new u
      '{xcfp_pkg::CHAR_N,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_E,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_R,     1'b1, MARK_NONE},
      '{8'h01,                1'b1, MARK_NONE},  // length one, checksum right after ':'
      '{xcfp_pkg::CHAR_COLON, 1'b1, MARK_NONE},
      '{8'h00,                1'b1, MARK_BAD},
      '{xcfp_pkg::CHAR_U,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_N,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_E,     1'b1, MARK_NONE},
      '{xcfp_pkg::CHAR_U,     1'b1, MARK_NONE}   // wrong where r is due, taken as a new u
   };

   function automatic hunt_phase_type hunt_from(input logic [7:0] b);
      return (b == xcfp_pkg::CHAR_U) ? HUNT_N : HUNT_U;
   endfunction

   function automatic xcfp_pkg::rsp_word_type parse_byte(input logic [7:0] b);
      xcfp_pkg::rsp_word_type w;
      w = '0;
      w.data_out = b;
      case (hunt_phase)
         HUNT_U: hunt_phase = hunt_from(b);
         HUNT_N: begin
            if (b == xcfp_pkg::CHAR_N) hunt_phase = HUNT_E;
            else if (b != xcfp_pkg::CHAR_U) hunt_phase = HUNT_U;
         end
         HUNT_E: hunt_phase = (b == xcfp_pkg::CHAR_E) ? HUNT_R : hunt_from(b);
         HUNT_R: hunt_phase = (b == xcfp_pkg::CHAR_R) ? GET_LEN : hunt_from(b);
         GET_LEN: begin
            bytes_due  = b;
            hunt_phase = GET_COLON;
         end
         GET_COLON: begin
            if (b == xcfp_pkg::CHAR_COLON) begin
               frame_xor  = xcfp_pkg::HDR_XOR ^ bytes_due;
               hunt_phase = BODY_FIRST;
            end else begin
               hunt_phase = hunt_from(b);
            end
         end
         default: begin
            bytes_due = bytes_due - 8'd1;
            if (bytes_due != 8'd0) begin
               w.body_valid = 1'b1;
               w.first_body = (hunt_phase == BODY_FIRST);
               frame_xor    = frame_xor ^ b;
               hunt_phase   = BODY_REST;
            end else begin
               w.frame_ok  = (b == frame_xor);
               w.frame_bad = (b != frame_xor);
               hunt_phase  = HUNT_U;
            end
         end
      endcase
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // predict on every accepted byte, check every accepted result word
   always @(posedge clock) begin
      typed_word_type         tw;
      xcfp_pkg::rsp_word_type want;
      xcfp_pkg::rsp_word_type seen;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tw   = typed_q.pop_front();
            want = parse_byte(req_chan.rx_byte);
            if (tw.typed) want = tw.word;
            expected_words.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = {rsp_chan.data_out, rsp_chan.body_valid, rsp_chan.first_body,
                    rsp_chan.frame_ok, rsp_chan.frame_bad};
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: data_out %h", seen.data_out);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("data_out", want.data_out, seen.data_out);
               check_field("body_valid", 8'(want.body_valid), 8'(seen.body_valid));
               check_field("first_body", 8'(want.first_body), 8'(seen.first_body));
               check_field("frame_ok", 8'(want.frame_ok), 8'(seen.frame_ok));
               check_field("frame_bad", 8'(want.frame_bad), 8'(seen.frame_bad));
            end
            word_count++;
            body_count += seen.body_valid;
            ok_count   += seen.frame_ok;
            bad_count  += seen.frame_bad;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_words.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver pacing, with a long hold-off counted here on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            stall_left    = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input bit typed,
                            input xcfp_pkg::rsp_word_type word);
      typed_q.push_back('{typed, word});
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(b, 1'b0, '0);
   endtask

   // zero length wraps to 255 body bytes
   task automatic send_frame(input logic [7:0] len, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      int         n_body;
      sum    = xcfp_pkg::HDR_XOR ^ len;
      n_body = (len == 8'd0) ? 255 : int'(len) - 1;
      send_byte(xcfp_pkg::CHAR_U);
      send_byte(xcfp_pkg::CHAR_N);
      send_byte(xcfp_pkg::CHAR_E);
      send_byte(xcfp_pkg::CHAR_R);
      send_byte(len);
      send_byte(xcfp_pkg::CHAR_COLON);
      for (int i = 0; i < n_body; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         send_byte(b);
      end
      if (good_sum) begin
         b = sum;
      end else begin
         b = ($urandom_range(0, 3) == 0) ? xcfp_pkg::CHAR_U : 8'($urandom);
         if (b == sum) b = sum ^ 8'h01;
      end
      send_byte(b);
   endtask

   // header cut short after one to five bytes, then a byte that may break it
   task automatic send_broken();
      int k;
      k = $urandom_range(1, 5);
      for (int i = 0; i < k; i++) begin
         case (i)
            0:       send_byte(xcfp_pkg::CHAR_U);
            1:       send_byte(xcfp_pkg::CHAR_N);
            2:       send_byte(xcfp_pkg::CHAR_E);
            3:       send_byte(xcfp_pkg::CHAR_R);
            default: send_byte(8'($urandom));
         endcase
      end
      send_byte(($urandom_range(0, 2) == 0) ? xcfp_pkg::CHAR_U : 8'($urandom));
   endtask

   task automatic drain_all();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      int req_pace [NUM_PHASES];
      int rsp_pace [NUM_PHASES];
      int phase_start;
      int pick;
      req_pace = '{0, 62, 0, 19};
      rsp_pace = '{0, 0, 62, 19};
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      repeat (2) @(posedge clock);
      reset      <= 1'b0;
      hunt_phase = HUNT_U;
      bytes_due  = 8'd0;
      frame_xor  = 8'd0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_word(dir_table[i].rx, dir_table[i].typed, {dir_table[i].rx, dir_table[i].marks});

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_all();
         req_idle_pct = req_pace[p];
         rsp_idle_pct = rsp_pace[p];
         phase_start  = sent_count;
         if (p == 0) begin
            stall_request = 1'b1;
            send_frame(8'd0, 1'b1);
         end
         while (sent_count - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               send_frame(($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 60))
                                                       : 8'($urandom_range(1, 12)),
                          $urandom_range(0, 99) < 75);
            end else if (pick < 85) begin
               send_broken();
            end else begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
         end
      end

      drain_all();
      repeat (END_SETTLE) @(posedge clock);
      $display("sent %0d bytes in %0d pacing phases, a zero length frame included",
               sent_count, NUM_PHASES);
      $display("checked %0d words: %0d body bytes, %0d good and %0d bad checksums",
               word_count, body_count, ok_count, bad_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[xor_checked_frame_parser_top.f]
+incdir+hw/rtl
hw/rtl/xcfp_pkg.sv
hw/rtl/xcfp_chan_if.sv
hw/rtl/xcfp_core.sv
hw/rtl/xor_checked_frame_parser_top.sv
tb/tb_top.sv
